/* hdl/pse_pkg.sv */
// ----------------------------------------------------------------------------
// Prime sieve engine package
// Shared widths, default sizing and sequencer states of the sieve engine.
// ----------------------------------------------------------------------------
package pse_pkg;

    // Width of the limit field on the command port.
    localparam int LIMIT_W = 13;

    // Width of the word index field on the result port.
    localparam int WORD_INDEX_W = 6;

    // Number of flag bits carried by one result word.
    localparam int WORD_BITS = 64;

    // Log2 of the word size, used to split a value into word and bit.
    localparam int BIT_SEL_W = 6;

    // Default size of the flag store, in values.
    localparam int DEFAULT_MAX_LIMIT = 4096;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_BASE_TEST,
        ST_BASE_CHECK,
        ST_MULT_READ,
        ST_MULT_WRITE,
        ST_EMIT_READ,
        ST_EMIT
    } state_t;

endpackage

/* hdl/prime_sieve_engine_core.sv */
// ----------------------------------------------------------------------------
// Prime sieve engine core
// Marks primes below a given limit with a sieve and streams the flags out
// as 64-bit words, bit b of word k standing for value 64k+b.
// ----------------------------------------------------------------------------
// Usage:
//   Drive limit and raise start while busy is low; that beat is taken at the
//   rising edge and busy rises on the next cycle. Limits above MAX_LIMIT are
//   clamped to MAX_LIMIT.
//   The block then sets every flag of the store (one 64-bit word per cycle),
//   strikes multiples of each surviving base whose square is below the limit
//   (a read of the store to test each base, a read-modify-write of the word
//   store for each multiple struck, and a closing check to end each prime's
//   pass), and finally emits ceil(limit/64) words, at least one, reading each
//   word from the store before it is emitted.
//   Each result beat is held on word_index, prime_flags and last_word for one
//   cycle while result_valid is high; last_word marks the final beat, after
//   which busy falls. The receiver cannot stall the result beats.
//   Reset returns the sequencer to idle; the flag store needs no clearing
//   since every run rewrites it in full before reading it.
// ----------------------------------------------------------------------------
module prime_sieve_engine_core #(
    parameter int MAX_LIMIT = pse_pkg::DEFAULT_MAX_LIMIT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pse_pkg::LIMIT_W-1:0]       limit,
    output logic                              result_valid,
    output logic [pse_pkg::WORD_INDEX_W-1:0]  word_index,
    output logic [pse_pkg::WORD_BITS-1:0]     prime_flags,
    output logic                              last_word
);

    localparam int LW    = pse_pkg::LIMIT_W;
    localparam int WI    = pse_pkg::WORD_INDEX_W;
    localparam int WB    = pse_pkg::WORD_BITS;
    localparam int BS    = pse_pkg::BIT_SEL_W;
    localparam int SQ_W  = LW + 1;
    localparam int WORDS = (MAX_LIMIT + WB - 1) / WB;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [LW-1:0] MAX_LIM_L  = LW'(MAX_LIMIT);
    localparam logic [WI-1:0] LAST_CLEAR = WI'(WORDS - 1);

    // Flag store, one 64-bit word per entry.
    logic [WB-1:0] flag_mem [WORDS];
    logic [WB-1:0] rd_data_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WB-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // Sequencer and datapath registers.
    pse_pkg::state_t state_reg, state_next;
    logic [LW-1:0]   lim_reg, lim_next;
    logic [LW-1:0]   base_reg, base_next;
    logic [SQ_W-1:0] sq_reg, sq_next;
    logic [LW-1:0]   mult_reg, mult_next;
    logic [WI-1:0]   word_reg, word_next;

    // Derived values.
    logic [LW-1:0]   lim_sat;
    logic [LW-1:0]   lim_minus_one;
    logic [WI-1:0]   last_k;
    logic            sq_done;
    logic            mult_done;
    logic            base_flag;
    logic            is_last;
    logic [LW-1:0]   word_base;
    logic [LW:0]     word_top;
    logic [BS-1:0]   rem_bits;
    logic [WB-1:0]   range_mask;
    logic [WB-1:0]   masked_word;

    // Clamp the incoming limit.
    assign lim_sat = (limit > MAX_LIM_L) ? MAX_LIM_L : limit;

    // Index of the final word: zero for a zero limit, else (limit-1)/64.
    assign lim_minus_one = lim_reg - LW'(1);
    assign last_k        = (lim_reg == '0) ? '0 : lim_minus_one[BS+WI-1:BS];
    assign is_last       = (word_reg == last_k);

    // Loop-end compares of the strike passes.
    assign sq_done   = (sq_reg >= {1'b0, lim_reg});
    assign mult_done = (mult_reg >= lim_reg);
    assign base_flag = rd_data_reg[base_reg[BS-1:0]];

    // Mask of the values of the current word that lie in [2, limit).
    assign word_base = {{(LW-WI-BS){1'b0}}, word_reg, {BS{1'b0}}};
    assign word_top  = {1'b0, word_base} + (LW+1)'(WB);
    assign rem_bits  = BS'(lim_reg - word_base);

    always_comb
    begin
        if ({1'b0, lim_reg} >= word_top) begin
            range_mask = '1;
        end else begin
            range_mask = (WB'(1) << rem_bits) - WB'(1);
        end
        if (word_reg == '0) begin
            range_mask[1:0] = 2'b00;
        end
    end

    assign masked_word = rd_data_reg & range_mask;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pse_pkg::ST_IDLE:
            begin
                if (start) begin
                    state_next = pse_pkg::ST_CLEAR;
                end
            end
            pse_pkg::ST_CLEAR:
            begin
                if (word_reg == LAST_CLEAR) begin
                    state_next = pse_pkg::ST_BASE_TEST;
                end
            end
            pse_pkg::ST_BASE_TEST:
            begin
                if (sq_done) begin
                    state_next = pse_pkg::ST_EMIT_READ;
                end else begin
                    state_next = pse_pkg::ST_BASE_CHECK;
                end
            end
            pse_pkg::ST_BASE_CHECK:
            begin
                if (base_flag) begin
                    state_next = pse_pkg::ST_MULT_READ;
                end else begin
                    state_next = pse_pkg::ST_BASE_TEST;
                end
            end
            pse_pkg::ST_MULT_READ:
            begin
                if (mult_done) begin
                    state_next = pse_pkg::ST_BASE_TEST;
                end else begin
                    state_next = pse_pkg::ST_MULT_WRITE;
                end
            end
            pse_pkg::ST_MULT_WRITE:
            begin
                state_next = pse_pkg::ST_MULT_READ;
            end
            pse_pkg::ST_EMIT_READ:
            begin
                state_next = pse_pkg::ST_EMIT;
            end
            pse_pkg::ST_EMIT:
            begin
                if (is_last) begin
                    state_next = pse_pkg::ST_IDLE;
                end else begin
                    state_next = pse_pkg::ST_EMIT_READ;
                end
            end
            default:
            begin
                state_next = pse_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath controls and port outputs for each state.
    always_comb
    begin
        lim_next     = lim_reg;
        base_next    = base_reg;
        sq_next      = sq_reg;
        mult_next    = mult_reg;
        word_next    = word_reg;
        mem_we       = 1'b0;
        mem_waddr    = word_reg[AW-1:0];
        mem_wdata    = '1;
        mem_re       = 1'b0;
        mem_raddr    = word_reg[AW-1:0];
        busy         = 1'b1;
        result_valid = 1'b0;
        case (state_reg)
            pse_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start) begin
                    lim_next  = lim_sat;
                    word_next = '0;
                end
            end
            pse_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = word_reg[AW-1:0];
                mem_wdata = '1;
                if (word_reg == LAST_CLEAR) begin
                    base_next = LW'(2);
                    sq_next   = SQ_W'(4);
                    word_next = '0;
                end else begin
                    word_next = word_reg + WI'(1);
                end
            end
            pse_pkg::ST_BASE_TEST:
            begin
                mem_re    = ~sq_done;
                mem_raddr = base_reg[BS+AW-1:BS];
            end
            pse_pkg::ST_BASE_CHECK:
            begin
                if (base_flag) begin
                    mult_next = sq_reg[LW-1:0];
                end else begin
                    base_next = base_reg + LW'(1);
                    sq_next   = sq_reg + {base_reg, 1'b0} + SQ_W'(1);
                end
            end
            pse_pkg::ST_MULT_READ:
            begin
                if (mult_done) begin
                    base_next = base_reg + LW'(1);
                    sq_next   = sq_reg + {base_reg, 1'b0} + SQ_W'(1);
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = mult_reg[BS+AW-1:BS];
                end
            end
            pse_pkg::ST_MULT_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = mult_reg[BS+AW-1:BS];
                mem_wdata = rd_data_reg & ~(WB'(1) << mult_reg[BS-1:0]);
                mult_next = mult_reg + base_reg;
            end
            pse_pkg::ST_EMIT_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = word_reg[AW-1:0];
            end
            pse_pkg::ST_EMIT:
            begin
                result_valid = 1'b1;
                word_next    = word_reg + WI'(1);
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Result fields, meaningful while result_valid is high.
    assign word_index  = word_reg;
    assign prime_flags = masked_word;
    assign last_word   = is_last;

    // Flag store port: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            flag_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= flag_mem[mem_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= pse_pkg::ST_IDLE;
            base_reg  <= '0;
            mult_reg  <= '0;
            word_reg  <= '0;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
            mult_reg  <= mult_next;
            word_reg  <= word_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lim_reg <= lim_next;
        sq_reg  <= sq_next;
    end

endmodule
